>>> sv/assert_macros.svh
// Assertion macros used by the controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> sv/pidc_pkg.sv
// Package with the payload types, gain struct and constants of the PID controller.
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

  localparam int unsigned PosW     = 24;
  localparam int unsigned ErrW     = PosW + 1;
  localparam int unsigned GainW    = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned TorqueW  = 16;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned RegIdxW  = 2;

  localparam logic [LimitW-1:0] LimitReset = 15'd16384;

  localparam logic [RegIdxW-1:0] RegKp    = 2'd0;
  localparam logic [RegIdxW-1:0] RegKi    = 2'd1;
  localparam logic [RegIdxW-1:0] RegKd    = 2'd2;
  localparam logic [RegIdxW-1:0] RegLimit = 2'd3;

  typedef struct packed {
    logic signed [PosW-1:0] reference_position;
    logic signed [PosW-1:0] measured_position;
  } pidc_in_t;

  typedef struct packed {
    logic signed [TorqueW-1:0] torque_command;
    logic                      saturated;
  } pidc_out_t;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki_scaled;
    logic signed [GainW-1:0] kd_scaled;
    logic [LimitW-1:0]       torque_limit;
  } pidc_gains_t;

endpackage

`default_nettype wire

>>> sv/pid_position_controller_top.sv
// Top level of the PID position controller with clamping anti-windup.
// Path: a word accepted into the input stage is evaluated by pidc_core and lands in the
// result register, which holds it until the receiver takes it.
// Throughput: one word per cycle while the output is not stalled; the whole step is one pass through pidc_core.
// The integral and previous error update with each result, so back-to-back words chain.
// Reset (rst_ni, asynchronous, active low) clears both channels, the integral and
// the previous error, sets the gains to zero and the torque limit to 16384.
`timescale 1ns / 1ps
`default_nettype none

module pid_position_controller_top #(
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pidc_pkg::pidc_in_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pidc_pkg::pidc_out_t                 out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pidc_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [pidc_pkg::ApbDataW-1:0]  pwdata,
  output logic      [pidc_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready
);
  import pidc_pkg::*;
  `include "assert_macros.svh"

  pidc_gains_t gains;

  // Input stage: holds one word while its step is evaluated.
  logic     stage_valid_q;
  pidc_in_t sample_q;

  // Result register: parts the two handshakes so a stalled output
  // does not stop a new word from entering the input stage.
  logic      out_valid_q;
  pidc_out_t result_q;
  pidc_out_t result_d;

  // Controller state.
  logic signed [INTEGRAL_WIDTH-1:0] integral_q;
  logic signed [INTEGRAL_WIDTH-1:0] integral_d;
  logic signed [ErrW-1:0]           prev_error_q;
  logic signed [ErrW-1:0]           prev_error_d;

  logic advance;
  logic fire;
  logic in_accept;

  // Shorthands for the checks at the end of the module.
  logic                      out_stalled;
  logic                      out_sat;
  logic                      out_unsat;
  logic signed [TorqueW-1:0] out_cmd;
  logic signed [TorqueW-1:0] lim_cmd;

  pidc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains_o (gains)
  );

  pidc_core #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_core (
    .sample_i     (sample_q),
    .gains_i      (gains),
    .integral_i   (integral_q),
    .prev_error_i (prev_error_q),
    .result_o     (result_d),
    .integral_d_o (integral_d),
    .error_o      (prev_error_d)
  );

  // The result register can take a new value when it is empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = stage_valid_q && advance;
  assign in_ready_o = !stage_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_accept) begin
      stage_valid_q <= 1'b1;
    end else if (fire) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result_d;
    end
  end

  // The state moves only when a step actually completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q   <= '0;
      prev_error_q <= '0;
    end else if (fire) begin
      integral_q   <= integral_d;
      prev_error_q <= prev_error_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

  assign out_stalled = out_valid_o && !out_ready_i;
  assign out_sat     = out_valid_o && out_data_o.saturated;
  assign out_unsat   = out_valid_o && !out_data_o.saturated;
  assign out_cmd     = out_data_o.torque_command;
  assign lim_cmd     = $signed(TorqueW'(gains.torque_limit));

  // A stalled result must not let the state run ahead.
  `ASSERT_NEXT(a_state_holds_on_stall, clk_i, rst_ni, out_stalled, $stable({integral_q, prev_error_q}))
  // A clamped result sits exactly on one of the two limits.
  `ASSERT_IMPLIES(a_sat_on_limit, clk_i, rst_ni, out_sat, (out_cmd == lim_cmd) || (out_cmd == -lim_cmd))
  // An unclamped result lies strictly inside the limits.
  `ASSERT_IMPLIES(a_unsat_inside, clk_i, rst_ni, out_unsat, (out_cmd < lim_cmd) && (out_cmd > -lim_cmd))
  // Input backpressure only comes from a full stage that cannot drain.
  `ASSERT_IMPLIES(a_ready_low_only_full, clk_i, rst_ni, !in_ready_o, stage_valid_q && out_stalled)

endmodule

`default_nettype wire

>>> sv/pidc_regs.sv
// APB register file holding the controller gains and the torque limit.
`timescale 1ns / 1ps
`default_nettype none

module pidc_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pidc_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [pidc_pkg::ApbDataW-1:0]  pwdata,
  output logic      [pidc_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  output pidc_pkg::pidc_gains_t               gains_o
);
  import pidc_pkg::*;

  pidc_gains_t gains_q;
  logic [RegIdxW-1:0] reg_idx;
  logic write_en;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[ApbAddrW-1:2];
  assign write_en = psel && penable && pwrite && pready;
  assign gains_o  = gains_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp           <= '0;
      gains_q.ki_scaled    <= '0;
      gains_q.kd_scaled    <= '0;
      gains_q.torque_limit <= LimitReset;
    end else if (write_en) begin
      case (reg_idx)
        RegKp:    gains_q.kp           <= $signed(pwdata[GainW-1:0]);
        RegKi:    gains_q.ki_scaled    <= $signed(pwdata[GainW-1:0]);
        RegKd:    gains_q.kd_scaled    <= $signed(pwdata[GainW-1:0]);
        RegLimit: gains_q.torque_limit <= pwdata[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegKp:    prdata = ApbDataW'(unsigned'(gains_q.kp));
      RegKi:    prdata = ApbDataW'(unsigned'(gains_q.ki_scaled));
      RegKd:    prdata = ApbDataW'(unsigned'(gains_q.kd_scaled));
      RegLimit: prdata = ApbDataW'(gains_q.torque_limit);
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/pidc_core.sv
// Combinational PID step: error, saturating integral, products, shift and clamp.
`timescale 1ns / 1ps
`default_nettype none

module pidc_core #(
  parameter int unsigned INTEGRAL_WIDTH = 48
) (
  input  wire pidc_pkg::pidc_in_t                 sample_i,
  input  wire pidc_pkg::pidc_gains_t              gains_i,
  input  wire logic signed [INTEGRAL_WIDTH-1:0]   integral_i,
  input  wire logic signed [pidc_pkg::ErrW-1:0]   prev_error_i,
  output pidc_pkg::pidc_out_t                     result_o,
  output logic signed [INTEGRAL_WIDTH-1:0]        integral_d_o,
  output logic signed [pidc_pkg::ErrW-1:0]        error_o
);
  import pidc_pkg::*;

  // The integral product is split into two halves to keep each multiplier narrow.
  localparam int unsigned IW     = INTEGRAL_WIDTH;
  localparam int unsigned HalfW  = IW / 2;
  localparam int unsigned UpperW = IW - HalfW;
  localparam int unsigned SumW   = IW + GainW + 2;
  localparam int unsigned ShW    = SumW - FracBits;

  localparam logic signed [IW-1:0] AccMax = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] AccMin = {1'b1, {(IW-1){1'b0}}};

  logic signed [ErrW-1:0]           err;
  logic signed [ErrW:0]             diff;
  logic signed [IW:0]               acc_wide;
  logic signed [IW-1:0]             acc_sat;
  logic signed [GainW+ErrW-1:0]     p_kp;
  logic signed [GainW+ErrW:0]       p_kd;
  logic signed [GainW+HalfW:0]      p_ki_lo;
  logic signed [GainW+UpperW-1:0]   p_ki_hi;
  logic signed [SumW-1:0]           sum;
  logic signed [ShW-1:0]            shifted;
  logic signed [ShW-1:0]            lim_pos;
  logic signed [ShW-1:0]            lim_neg;
  logic                             sat;

  assign err  = ErrW'(sample_i.reference_position) - ErrW'(sample_i.measured_position);
  assign diff = (ErrW + 1)'(err) - (ErrW + 1)'(prev_error_i);

  // Saturating accumulate: overflow shows as a mismatch of the top two bits.
  assign acc_wide = (IW + 1)'(integral_i) + (IW + 1)'(err);
  always_comb begin
    if (acc_wide[IW] != acc_wide[IW-1]) begin
      acc_sat = acc_wide[IW] ? AccMin : AccMax;
    end else begin
      acc_sat = acc_wide[IW-1:0];
    end
  end

  assign p_kp    = gains_i.kp * err;
  assign p_kd    = gains_i.kd_scaled * diff;
  assign p_ki_lo = gains_i.ki_scaled * $signed({1'b0, acc_sat[HalfW-1:0]});
  assign p_ki_hi = gains_i.ki_scaled * $signed(acc_sat[IW-1:HalfW]);

  assign sum = SumW'(p_kp) + SumW'(p_kd) + (SumW'(p_ki_hi) <<< HalfW) + SumW'(p_ki_lo);

  // Arithmetic shift: rounds toward minus infinity.
  assign shifted = sum[SumW-1:FracBits];
  assign lim_pos = $signed(ShW'(gains_i.torque_limit));
  assign lim_neg = -lim_pos;

  always_comb begin
    sat                     = 1'b0;
    result_o.torque_command = shifted[TorqueW-1:0];
    if (shifted >= lim_pos) begin
      sat                     = 1'b1;
      result_o.torque_command = lim_pos[TorqueW-1:0];
    end else if (shifted <= lim_neg) begin
      sat                     = 1'b1;
      result_o.torque_command = lim_neg[TorqueW-1:0];
    end
    result_o.saturated = sat;
  end

  // Clamping anti-windup: the integral is frozen on a clamped sample.
  assign integral_d_o       = sat ? integral_i : acc_sat;
  assign error_o            = err;

endmodule

`default_nettype wire

>>> sim/tb_pid_position_controller_top.sv
// Self-checking testbench for the PID position controller, with a bit-exact torque predictor.
`timescale 1ns / 1ps

module tb_pid_position_controller_top;
  import pidc_pkg::*;

  // Width of the integral accumulator in the block under test.
  localparam int unsigned IntegralW = 48;
  localparam longint IntMax = (longint'(1) <<< (IntegralW - 1)) - 1;
  localparam longint IntMin = -IntMax - 1;

  // Cycles without any accepted word before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off plus one register programming pass.
  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 300;
  // Settling time after the drain, before the last check that every result arrived.
  localparam int SettleCycles  = 10;

  // The scoreboard keeps its own copy of the gains and of the controller state, and
  // predicts the torque word for every accepted sample word.
  class torque_scoreboard;
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] ki;
    logic signed [GainW-1:0] kd;
    logic [LimitW-1:0]       limit;
    longint                  integral;
    longint                  prev_error;
    pidc_out_t               expected_q[$];
    int                      errors;

    function new();
      kp         = '0;
      ki         = '0;
      kd         = '0;
      limit      = LimitReset;
      integral   = 0;
      prev_error = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [ApbDataW-1:0] value);
      case (idx)
        RegKp:    kp = value;
        RegKi:    ki = value;
        RegKd:    kd = value;
        RegLimit: limit = value[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ApbDataW-1:0] reg_value(logic [RegIdxW-1:0] idx);
      case (idx)
        RegKp:   return kp;
        RegKi:   return ki;
        RegKd:   return kd;
        default: return ApbDataW'(limit);
      endcase
    endfunction

    // One control step: error, saturating integral candidate, full-precision sum,
    // arithmetic shift (floor), symmetric clamp and integrator freeze on clamp.
    function pidc_out_t compute_torque(pidc_in_t w);
      longint             err;
      longint             diff;
      longint             acc;
      logic signed [95:0] g_p;
      logic signed [95:0] g_i;
      logic signed [95:0] g_d;
      logic signed [95:0] e_w;
      logic signed [95:0] a_w;
      logic signed [95:0] d_w;
      logic signed [95:0] lim_w;
      logic signed [95:0] neg_lim;
      logic signed [95:0] total;
      logic signed [95:0] scaled;
      pidc_out_t          r;
      err  = longint'($signed(w.reference_position)) - longint'($signed(w.measured_position));
      diff = err - prev_error;
      acc  = integral + err;
      if (acc > IntMax) begin
        acc = IntMax;
      end else if (acc < IntMin) begin
        acc = IntMin;
      end
      g_p     = kp;
      g_i     = ki;
      g_d     = kd;
      e_w     = err;
      a_w     = acc;
      d_w     = diff;
      lim_w   = $signed({1'b0, limit});
      neg_lim = -lim_w;
      total   = g_p * e_w + g_i * a_w + g_d * d_w;
      scaled  = total >>> FracBits;
      r.saturated = 1'b1;
      if (scaled >= lim_w) begin
        r.torque_command = lim_w[TorqueW-1:0];
      end else if (scaled <= neg_lim) begin
        r.torque_command = neg_lim[TorqueW-1:0];
      end else begin
        r.saturated      = 1'b0;
        r.torque_command = scaled[TorqueW-1:0];
      end
      if (!r.saturated) begin
        integral = acc;
      end
      prev_error = err;
      return r;
    endfunction

    function void note_sample(pidc_in_t w);
      expected_q.push_back(compute_torque(w));
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(pidc_out_t got);
      pidc_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result torque=%0d saturated=%0b",
                         $signed(got.torque_command), got.saturated));
        return;
      end
      want = expected_q.pop_front();
      if (got.torque_command !== want.torque_command) begin
        report($sformatf("torque_command got %0d want %0d",
                         $signed(got.torque_command), $signed(want.torque_command)));
      end
      if (got.saturated !== want.saturated) begin
        report($sformatf("saturated got %0b want %0b", got.saturated, want.saturated));
      end
    endtask
  endclass

  // All block inputs start at known values at time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  pidc_in_t              in_data_i   = '0;
  logic                  out_ready_i = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [ApbAddrW-1:0]   paddr       = '0;
  logic [ApbDataW-1:0]   pwdata      = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  pidc_out_t             out_data_o;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  torque_scoreboard sb = new();

  // Idling controls shared between the sender, the receiver and the main sequence.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_arm      = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  pid_position_controller_top #(
    .INTEGRAL_WIDTH(IntegralW)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitor. It samples right after the rising edge, before any nonblocking update of
  // this step lands, so it sees exactly what the block saw at the edge. A sample word
  // is noted before a result is checked; results always belong to older samples.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_sample(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_data_o);
      end
    end
  end

  // Receiver. It stalls at random by the current percentage. When a hold-off is armed
  // it keeps ready low for a long stretch that it counts itself, so the result
  // register fills and the block must push back on its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without any accepted word means the block has hung.
  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one sample word, after a random number of idle cycles, and returns at the
  // edge where it was taken. Valid is left high so the next word can follow directly.
  task automatic drive_word(input pidc_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_pair(input logic [PosW-1:0] ref_pos, input logic [PosW-1:0] meas_pos);
    pidc_in_t w;
    w.reference_position = ref_pos;
    w.measured_position  = meas_pos;
    drive_word(w);
  endtask

  // Most random words track the reference closely, so that the output stays inside
  // the clamp and the integral and derivative paths matter. The rest are full-range.
  function automatic pidc_in_t random_word();
    pidc_in_t w;
    int       delta;
    longint   meas;
    w.reference_position = PosW'($urandom);
    if ($urandom_range(99) < 30) begin
      w.measured_position = PosW'($urandom);
    end else begin
      delta = int'($urandom_range(1 << $urandom_range(15)));
      if ($urandom_range(1) == 1) begin
        delta = -delta;
      end
      meas = longint'($signed(w.reference_position)) - delta;
      if (meas > 64'sd8388607) begin
        meas = 64'sd8388607;
      end else if (meas < -64'sd8388608) begin
        meas = -64'sd8388608;
      end
      w.measured_position = meas[PosW-1:0];
    end
    return w;
  endfunction

  // A gain of random sign whose magnitude fits in the given number of bits.
  function automatic logic [GainW-1:0] rand_gain(input int bits);
    logic [GainW-1:0] g;
    g = $urandom & ((32'd1 << bits) - 1);
    if ($urandom_range(1) == 1) begin
      g = -g;
    end
    return g;
  endfunction

  // A register write: setup phase, then access until pready, then the bus returns to idle so
  // the next transfer starts in a fresh time step.
  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // A register read, compared with the value the scoreboard holds for it.
  task automatic apb_check(input logic [RegIdxW-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== sb.reg_value(idx)) begin
      sb.report($sformatf("register %0d reads %h want %h", idx, prdata, sb.reg_value(idx)));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the sender and waits until every predicted result has been taken. Every
  // sample yields exactly one result, so an empty queue means the block is idle.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_gains(input logic [GainW-1:0] kp, input logic [GainW-1:0] ki,
                               input logic [GainW-1:0] kd, input logic [ApbDataW-1:0] lim);
    settle();
    apb_write(RegKp, kp);
    apb_write(RegKi, ki);
    apb_write(RegKd, kd);
    apb_write(RegLimit, lim);
    apb_check(RegKp);
    apb_check(RegKi);
    apb_check(RegKd);
    apb_check(RegLimit);
  endtask

  // Main sequence: reset, a directed part, then eight random phases with different
  // gains and idling, and finally the drain and the verdict.
  initial begin
    int n_items;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values read back, and a zero-gain step gives a zero, unclamped output.
    apb_check(RegKp);
    apb_check(RegKi);
    apb_check(RegKd);
    apb_check(RegLimit);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h000123, 24'h000000);

    // Fractional gains: a negative result with fraction bits checks the floor shift.
    program_gains(32'h0001_8000, 32'h0000_1000, 32'h0000_4000, 32'd32767);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'h000001, 24'h000002);
    send_pair(24'h000002, 24'h000001);
    send_pair(24'hFFFFFB, 24'h000003);
    send_pair(24'h001000, 24'h000000);
    send_pair(24'h000000, 24'h001000);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h7FFFFF, 24'h7FFFFF);
    send_pair(24'h800000, 24'h800000);

    // A zero limit clamps everything to zero and freezes the integral.
    program_gains(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'h000064, 24'h000000);
    send_pair(24'h000000, 24'h000064);

    // Extreme gains with the smallest nonzero limit.
    program_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h000000, 24'h000000);

    // Opposite extremes; the limit word carries junk above its 15 bits.
    program_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_7FFF);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h800000, 24'h7FFFFF);
    send_pair(24'h000003, 24'hFFFFFD);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          program_gains(32'h0001_0000, 32'h0000_0100, 32'h0000_2000, 32'd32767);
          send_idle_pct = 0;
          recv_idle_pct = 0;
          n_items       = 150;
        end
        1: begin
          program_gains(rand_gain(17), rand_gain(10), rand_gain(15), $urandom_range(32767));
          send_idle_pct = 48;
          recv_idle_pct = 0;
          n_items       = 150;
        end
        2: begin
          program_gains(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'd32767);
          send_idle_pct = 0;
          recv_idle_pct = 48;
          n_items       = 100;
        end
        3: begin
          program_gains(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
          send_idle_pct = 20;
          recv_idle_pct = 20;
          n_items       = 100;
        end
        4: begin
          program_gains(rand_gain(17), rand_gain(10), rand_gain(15), 32'd0);
          send_idle_pct = 48;
          recv_idle_pct = 0;
          n_items       = 100;
        end
        5: begin
          // The receiver holds off for a long stretch while words keep coming.
          program_gains(rand_gain(17), rand_gain(8), rand_gain(14), $urandom_range(32767));
          send_idle_pct = 0;
          recv_idle_pct = 0;
          n_items       = 150;
          hold_arm      = 1'b1;
        end
        6: begin
          program_gains($urandom, $urandom, $urandom, $urandom);
          send_idle_pct = 20;
          recv_idle_pct = 20;
          n_items       = 150;
        end
        default: begin
          program_gains(rand_gain(16), 32'h0000_0010, 32'h0000_0000, 32'd32767);
          send_idle_pct = 0;
          recv_idle_pct = 48;
          n_items       = 200;
        end
      endcase
      repeat (n_items) drive_word(random_word());
    end

    settle();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
